// ===== rtl/bpfa_pkg.sv =====
// Shared types, codes and constants for the bitmap page-frame allocator.
`default_nettype none

package bpfa_pkg;

  // Field widths fixed by the interface
  localparam int FrameW = 24;
  localparam int CountW = 13;

  // Bitmap row organization: one memory word holds this many frames
  localparam int WordBits = 64;
  localparam int BitIdxW  = 6;

  // Counter ceiling and reset count
  localparam logic [CountW-1:0] AvailMax      = 13'h1FFF;
  localparam logic [CountW-1:0] FrameCountRst = 13'd4096;

  typedef enum logic [1:0] {
    ACT_ALLOC      = 2'd0,
    ACT_ALLOC_KERN = 2'd1,
    ACT_FREE       = 2'd2,
    ACT_QUERY      = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK           = 2'd0,
    STAT_NO_FREE      = 2'd1,
    STAT_OUT_OF_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CAND_OK           = 2'd0,
    CAND_OUT_OF_RANGE = 2'd1,
    CAND_KERNEL       = 2'd2
  } cand_e;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_BASE_FRAME  = 1'b0,
    REG_FRAME_COUNT = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } state_e;

  // Configuration handed from the register block to the engine
  typedef struct packed {
    logic [FrameW-1:0] base_frame;
    logic [CountW-1:0] frame_count;
    logic              count_wr;
    logic [CountW-1:0] count_wdata;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/bpfa_cfg.sv =====
// APB-style configuration registers: base frame and frame count.
`default_nettype none

module bpfa_cfg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output bpfa_pkg::cfg_t   cfg_o
);

  logic [bpfa_pkg::FrameW-1:0] base_q, base_d;
  logic [bpfa_pkg::CountW-1:0] count_q, count_d;
  logic                        wr_en;
  bpfa_pkg::reg_e              reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = bpfa_pkg::reg_e'(paddr[2]);

  // Register write decode
  always_comb begin
    base_d  = base_q;
    count_d = count_q;
    if (wr_en) begin
      unique case (reg_sel)
        bpfa_pkg::REG_BASE_FRAME:  base_d  = pwdata[bpfa_pkg::FrameW-1:0];
        bpfa_pkg::REG_FRAME_COUNT: count_d = pwdata[bpfa_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      count_q <= bpfa_pkg::FrameCountRst;
    end else begin
      base_q  <= base_d;
      count_q <= count_d;
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_sel)
      bpfa_pkg::REG_BASE_FRAME:  prdata = 32'(base_q);
      bpfa_pkg::REG_FRAME_COUNT: prdata = 32'(count_q);
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o.base_frame  = base_q;
  assign cfg_o.frame_count = count_q;
  assign cfg_o.count_wr    = wr_en && (reg_sel == bpfa_pkg::REG_FRAME_COUNT);
  assign cfg_o.count_wdata = pwdata[bpfa_pkg::CountW-1:0];

endmodule

`default_nettype wire

// ===== rtl/bpfa_scan.sv =====
// Masked first-clear-bit search over one bitmap row.
`default_nettype none

module bpfa_scan (
  input  wire logic [bpfa_pkg::WordBits-1:0] word_i,
  input  wire logic                          first_row_i,
  input  wire logic                          last_row_i,
  input  wire logic [bpfa_pkg::BitIdxW-1:0]  lo_i,
  input  wire logic [bpfa_pkg::BitIdxW-1:0]  hi_i,
  output logic                               found_o,
  output logic [bpfa_pkg::BitIdxW-1:0]       pos_o
);

  localparam logic [bpfa_pkg::BitIdxW-1:0] TopBit = bpfa_pkg::BitIdxW'(bpfa_pkg::WordBits - 1);

  logic [bpfa_pkg::WordBits-1:0] lo_mask, hi_mask, cand;

  // Only bits at or above the hint and below the managed count qualify
  assign lo_mask = first_row_i ? ({bpfa_pkg::WordBits{1'b1}} << lo_i)
                               : {bpfa_pkg::WordBits{1'b1}};
  assign hi_mask = last_row_i ? ({bpfa_pkg::WordBits{1'b1}} >> (TopBit - hi_i))
                              : {bpfa_pkg::WordBits{1'b1}};
  assign cand    = ~word_i & lo_mask & hi_mask;

  // Lowest set candidate bit
  always_comb begin
    found_o = |cand;
    pos_o   = '0;
    for (int j = bpfa_pkg::WordBits - 1; j >= 0; j--) begin
      if (cand[j]) pos_o = bpfa_pkg::BitIdxW'(j);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bpfa_engine.sv =====
// Bitmap memories, hint and counter, with the sequencer for the four actions.
`default_nettype none

module bpfa_engine #(
  parameter int MAX_FRAMES = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire bpfa_pkg::cfg_t                cfg_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    action_i,
  input  wire logic [bpfa_pkg::FrameW-1:0]   frame_number_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         status_o,
  output logic [bpfa_pkg::FrameW-1:0]        granted_frame_o,
  output logic [1:0]                         candidate_code_o,
  output logic [bpfa_pkg::CountW-1:0]        available_count_o
);

  localparam int WB   = bpfa_pkg::WordBits;
  localparam int BW   = bpfa_pkg::BitIdxW;
  localparam int FW   = bpfa_pkg::FrameW;
  localparam int CW   = bpfa_pkg::CountW;
  localparam int ROWS = (MAX_FRAMES + WB - 1) / WB;
  localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int NW   = $clog2(MAX_FRAMES + 1);
  localparam logic [CW-1:0] AvailRst = CW'((MAX_FRAMES < 4096) ? MAX_FRAMES : 4096);
  localparam logic [RAW-1:0] LastClr = RAW'(ROWS - 1);

  // Bitmap memories, one row of frames per word
  logic [WB-1:0] amem [ROWS];
  logic [WB-1:0] kmem [ROWS];
  logic [WB-1:0] arow_q, krow_q;

  bpfa_pkg::state_e state_q, state_d;
  bpfa_pkg::action_e act_q, act_d;
  logic [FW-1:0]  frame_q, frame_d;
  logic [RAW-1:0] row_q, row_d;
  logic [NW-1:0]  idx_q, idx_d;
  logic [NW-1:0]  hint_q, hint_d;
  logic [CW-1:0]  avail_q, avail_d;
  logic [RAW-1:0] clr_q, clr_d;
  bpfa_pkg::status_e res_status_q, res_status_d;
  bpfa_pkg::cand_e   res_code_q, res_code_d;
  logic [FW-1:0]  res_granted_q, res_granted_d;

  logic          out_valid_q, out_valid_d;
  logic [1:0]    out_status_q, out_status_d;
  logic [1:0]    out_code_q, out_code_d;
  logic [FW-1:0] out_granted_q, out_granted_d;
  logic [CW-1:0] out_avail_q, out_avail_d;

  logic           mem_we, mem_re;
  logic [RAW-1:0] waddr, raddr;
  logic [WB-1:0]  awdata, kwdata;

  logic [NW-1:0]  n_eff, n_wr, n_m1, found_idx;
  logic [RAW-1:0] hint_row, last_row, idx_row;
  logic [FW-1:0]  rel;
  logic           in_range, is_alloc, found, out_free;
  logic [BW-1:0]  pos, idx_bit;
  logic [WB-1:0]  idx_onehot, pos_onehot;

  // Effective frame counts (current and being written)
  assign n_eff = (32'(cfg_i.frame_count) > MAX_FRAMES) ? NW'(MAX_FRAMES)
                                                       : NW'(cfg_i.frame_count);
  assign n_wr  = (32'(cfg_i.count_wdata) > MAX_FRAMES) ? NW'(MAX_FRAMES)
                                                       : NW'(cfg_i.count_wdata);
  assign n_m1     = n_eff - NW'(1);
  assign last_row = RAW'(n_m1 >> BW);
  assign hint_row = RAW'(hint_q >> BW);

  // Range check for free and query
  assign rel      = frame_q - cfg_i.base_frame;
  assign in_range = (frame_q >= cfg_i.base_frame) && (rel < FW'(n_eff));
  assign idx_row  = RAW'(NW'(rel) >> BW);

  assign is_alloc   = (act_q == bpfa_pkg::ACT_ALLOC) || (act_q == bpfa_pkg::ACT_ALLOC_KERN);
  assign idx_bit    = BW'(idx_q);
  assign idx_onehot = WB'(1) << idx_bit;
  assign pos_onehot = WB'(1) << pos;
  assign found_idx  = NW'({row_q, pos});
  assign out_free   = !out_valid_q || out_ready_i;

  bpfa_scan u_scan (
    .word_i      (arow_q),
    .first_row_i (row_q == hint_row),
    .last_row_i  (row_q == last_row),
    .lo_i        (BW'(hint_q)),
    .hi_i        (BW'(n_m1)),
    .found_o     (found),
    .pos_o       (pos)
  );

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      amem[waddr] <= awdata;
      kmem[waddr] <= kwdata;
    end
    if (mem_re) begin
      arow_q <= amem[raddr];
      krow_q <= kmem[raddr];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpfa_pkg::ST_CLEAR: if (clr_q == LastClr) state_d = bpfa_pkg::ST_IDLE;
      bpfa_pkg::ST_IDLE:  if (in_valid_i) state_d = bpfa_pkg::ST_CHECK;
      bpfa_pkg::ST_CHECK: begin
        if (is_alloc) begin
          state_d = (hint_q >= n_eff) ? bpfa_pkg::ST_DONE : bpfa_pkg::ST_READ;
        end else begin
          state_d = in_range ? bpfa_pkg::ST_READ : bpfa_pkg::ST_DONE;
        end
      end
      bpfa_pkg::ST_READ: state_d = bpfa_pkg::ST_EVAL;
      bpfa_pkg::ST_EVAL: begin
        if (is_alloc && !found && (row_q != last_row)) state_d = bpfa_pkg::ST_EVAL;
        else                                           state_d = bpfa_pkg::ST_DONE;
      end
      bpfa_pkg::ST_DONE: if (out_free) state_d = bpfa_pkg::ST_IDLE;
      default: state_d = bpfa_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    act_d         = act_q;
    frame_d       = frame_q;
    row_d         = row_q;
    idx_d         = idx_q;
    hint_d        = hint_q;
    avail_d       = avail_q;
    clr_d         = clr_q;
    res_status_d  = res_status_q;
    res_code_d    = res_code_q;
    res_granted_d = res_granted_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_status_d  = out_status_q;
    out_code_d    = out_code_q;
    out_granted_d = out_granted_q;
    out_avail_d   = out_avail_q;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    waddr         = row_q;
    raddr         = row_q;
    awdata        = arow_q;
    kwdata        = krow_q;
    in_ready_o    = 1'b0;

    unique case (state_q)
      bpfa_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        waddr  = clr_q;
        awdata = '0;
        kwdata = '0;
        clr_d  = clr_q + RAW'(1);
      end
      bpfa_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        act_d         = bpfa_pkg::action_e'(action_i);
        frame_d       = frame_number_i;
        res_status_d  = bpfa_pkg::STAT_OK;
        res_code_d    = bpfa_pkg::CAND_OK;
        res_granted_d = '0;
      end
      bpfa_pkg::ST_CHECK: begin
        if (is_alloc) begin
          row_d = hint_row;
          if (hint_q >= n_eff) res_status_d = bpfa_pkg::STAT_NO_FREE;
        end else begin
          row_d = idx_row;
          idx_d = NW'(rel);
          if (!in_range) begin
            if (act_q == bpfa_pkg::ACT_FREE) res_status_d = bpfa_pkg::STAT_OUT_OF_RANGE;
            else                             res_code_d   = bpfa_pkg::CAND_OUT_OF_RANGE;
          end
        end
      end
      bpfa_pkg::ST_READ: begin
        mem_re = 1'b1;
      end
      bpfa_pkg::ST_EVAL: begin
        unique case (act_q) inside
          bpfa_pkg::ACT_ALLOC, bpfa_pkg::ACT_ALLOC_KERN: begin
            if (found) begin
              mem_we        = 1'b1;
              awdata        = arow_q | pos_onehot;
              hint_d        = found_idx + NW'(1);
              res_granted_d = cfg_i.base_frame + FW'(found_idx);
              if (act_q == bpfa_pkg::ACT_ALLOC_KERN) begin
                kwdata = krow_q | pos_onehot;
                if (avail_q != '0) avail_d = avail_q - CW'(1);
              end
            end else if (row_q != last_row) begin
              // Prefetch the next row while this one is checked
              mem_re = 1'b1;
              raddr  = row_q + RAW'(1);
              row_d  = row_q + RAW'(1);
            end else begin
              res_status_d = bpfa_pkg::STAT_NO_FREE;
            end
          end
          bpfa_pkg::ACT_FREE: begin
            mem_we = 1'b1;
            awdata = arow_q & ~idx_onehot;
            kwdata = krow_q & ~idx_onehot;
            if (hint_q > idx_q) hint_d = idx_q;
            if (krow_q[idx_bit] && (avail_q != bpfa_pkg::AvailMax)) avail_d = avail_q + CW'(1);
          end
          bpfa_pkg::ACT_QUERY: begin
            if (krow_q[idx_bit]) res_code_d = bpfa_pkg::CAND_KERNEL;
          end
          default: ;
        endcase
      end
      bpfa_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_status_d  = res_status_q;
          out_code_d    = res_code_q;
          out_granted_d = res_granted_q;
          out_avail_d   = avail_q;
        end
      end
      default: ;
    endcase

    // Count write reloads counter; user must write only when idle (not enforced)
    if (cfg_i.count_wr) avail_d = CW'(n_wr);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpfa_pkg::ST_CLEAR;
      clr_q       <= '0;
      hint_q      <= '0;
      avail_q     <= AvailRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      hint_q      <= hint_d;
      avail_q     <= avail_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    act_q         <= act_d;
    frame_q       <= frame_d;
    row_q         <= row_d;
    idx_q         <= idx_d;
    res_status_q  <= res_status_d;
    res_code_q    <= res_code_d;
    res_granted_q <= res_granted_d;
    out_status_q  <= out_status_d;
    out_code_q    <= out_code_d;
    out_granted_q <= out_granted_d;
    out_avail_q   <= out_avail_d;
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign candidate_code_o  = out_code_q;
  assign granted_frame_o   = out_granted_q;
  assign available_count_o = out_avail_q;

endmodule

`default_nettype wire

// ===== rtl/bitmap_page_frame_allocator_top.sv =====
// Top level of the bitmap page-frame allocator.
//
// Request channel (in_valid_i/in_ready_o) carries one beat per action:
// allocate, allocate kernel page, free or query, with a frame number for
// free and query. Each beat yields exactly one result beat on the
// response channel (out_valid_o/out_ready_i).
// Frame maps live in two 64-bit-wide single-port-style memories with a
// registered read; one row holds 64 frames.
// Free and query pass through the CHECK, READ, EVAL and DONE states;
// an allocate repeats EVAL once for each row scanned from the hint row
// (1 to ceil(MAX_FRAMES/64), i.e. up to 64 at 4096 frames). A request
// that fails its range or hint check goes from CHECK straight to DONE.
// One request is in work at a time; the next one is taken once the
// result has moved into the output register, so a stalled receiver
// holds one finished beat while the next request is worked on.
// Reset: a clearing pass zeroes every row of both maps; in_ready_o
// stays low until it ends. Configuration writes (APB, base at 0x0,
// frame count at 0x4) are taken at any time.
`default_nettype none

module bitmap_page_frame_allocator_top #(
  parameter int MAX_FRAMES = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [23:0] frame_number_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [23:0]      granted_frame_o,
  output logic [1:0]       candidate_code_o,
  output logic [12:0]      available_count_o
);

  bpfa_pkg::cfg_t cfg;

  // Configuration registers
  bpfa_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Bitmap engine
  bpfa_engine #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_engine (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .action_i          (action_i),
    .frame_number_i    (frame_number_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .granted_frame_o   (granted_frame_o),
    .candidate_code_o  (candidate_code_o),
    .available_count_o (available_count_o)
  );

endmodule

`default_nettype wire

// ===== tb/bitmap_page_frame_allocator_top_tb.sv =====
// Self-checking testbench for the bitmap page-frame allocator top level.
module bitmap_page_frame_allocator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MaxFrames  = 4096;
  localparam int          ClkPeriod  = 20;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned HoldAtBeat = 300;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned TailCycles = 100;
  localparam int unsigned PhaseBeats = 146;

  typedef struct {
    bpfa_pkg::action_e act;
    logic [23:0]       frame;
  } frame_request_t;

  typedef struct {
    bpfa_pkg::status_e status;
    logic [23:0]       granted;
    bpfa_pkg::cand_e   cand;
    logic [12:0]       avail;
  } frame_result_t;

  // Clock, reset and DUT ports; every input starts at a known value
  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        psel              = 1'b0;
  logic        penable           = 1'b0;
  logic        pwrite            = 1'b0;
  logic [2:0]  paddr             = '0;
  logic [31:0] pwdata            = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i        = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i          = '0;
  logic [23:0] frame_number_i    = '0;
  logic        out_valid_o;
  logic        out_ready_i       = 1'b0;
  logic [1:0]  status_o;
  logic [23:0] granted_frame_o;
  logic [1:0]  candidate_code_o;
  logic [12:0] available_count_o;

  // Shadow of the allocator state and its registers
  bit          alloc_bits [MaxFrames];
  bit          kernel_bits[MaxFrames];
  int unsigned hint_idx     = 0;
  int unsigned avail_frames = MaxFrames;
  logic [23:0] base_reg     = '0;
  logic [12:0] count_reg    = bpfa_pkg::FrameCountRst;

  frame_request_t request_q[$];
  frame_result_t  expected_q[$];
  frame_request_t next_req;
  frame_result_t  want;

  int unsigned beats_in       = 0;
  int unsigned hold_left      = 0;
  bit          hold_done      = 1'b0;
  bit          calm           = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  bitmap_page_frame_allocator_top #(
    .MAX_FRAMES(MaxFrames)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .frame_number_i   (frame_number_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .granted_frame_o  (granted_frame_o),
    .candidate_code_o (candidate_code_o),
    .available_count_o(available_count_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Frames actually managed: count is capped at the map size
  function automatic int unsigned managed_frames();
    return (count_reg > MaxFrames) ? MaxFrames : int'(count_reg);
  endfunction

  // Apply one request to the shadow state and return the result it yields
  function automatic frame_result_t apply_request(bpfa_pkg::action_e act, logic [23:0] frame);
    frame_result_t r;
    int unsigned   n;
    int unsigned   idx;
    int unsigned   rel;
    bit            found;
    bit            in_range;
    r.status  = bpfa_pkg::STAT_OK;
    r.granted = '0;
    r.cand    = bpfa_pkg::CAND_OK;
    n         = managed_frames();
    rel       = 32'(frame - base_reg);
    in_range  = (frame >= base_reg) && (rel < n);
    found     = 1'b0;
    case (act) inside
      bpfa_pkg::ACT_ALLOC, bpfa_pkg::ACT_ALLOC_KERN: begin
        // next fit: first clear bit at or above the hint
        for (idx = hint_idx; idx < n; idx++) begin
          if (!alloc_bits[idx]) begin
            found = 1'b1;
            break;
          end
        end
        if (found) begin
          alloc_bits[idx] = 1'b1;
          hint_idx        = idx + 1;
          r.granted       = base_reg + 24'(idx);
          if (act == bpfa_pkg::ACT_ALLOC_KERN) begin
            kernel_bits[idx] = 1'b1;
            if (avail_frames > 0) avail_frames--;
          end
        end else begin
          r.status = bpfa_pkg::STAT_NO_FREE;
        end
      end
      bpfa_pkg::ACT_FREE: begin
        if (in_range) begin
          alloc_bits[rel] = 1'b0;
          if (hint_idx > rel) hint_idx = rel;
          if (kernel_bits[rel]) begin
            kernel_bits[rel] = 1'b0;
            if (avail_frames < bpfa_pkg::AvailMax) avail_frames++;
          end
        end else begin
          r.status = bpfa_pkg::STAT_OUT_OF_RANGE;
        end
      end
      default: begin
        if (!in_range) r.cand = bpfa_pkg::CAND_OUT_OF_RANGE;
        else if (kernel_bits[rel]) r.cand = bpfa_pkg::CAND_KERNEL;
      end
    endcase
    r.avail = 13'(avail_frames);
    return r;
  endfunction

  // Request driver: presents the next queued beat, idles now and then
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_q.push_back(apply_request(bpfa_pkg::action_e'(action_i), frame_number_i));
        beats_in <= beats_in + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (request_q.size() != 0 && (calm || $urandom_range(99) >= 8)) begin
          next_req = request_q.pop_front();
          in_valid_i     <= 1'b1;
          action_i       <= next_req.act;
          frame_number_i <= next_req.frame;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off so the block backs up into its input
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && beats_in >= HoldAtBeat) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end
  end

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      mismatch_count++;
    end
  endtask

  // Result monitor: compares each beat with the oldest expectation
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected");
          mismatch_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", 32'(want.status), 32'(status_o));
          check_field("granted_frame", 32'(want.granted), 32'(granted_frame_o));
          check_field("candidate_code", 32'(want.cand), 32'(candidate_code_o));
          check_field("available_count", 32'(want.avail), 32'(available_count_o));
        end
      end
      out_ready_i <= (hold_left == 0) && (calm || $urandom_range(99) >= 8);
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("bitmap_page_frame_allocator_top_tb: FAIL");
    $finish;
  end

  task automatic queue_request(bpfa_pkg::action_e act, logic [23:0] frame);
    frame_request_t rq;
    rq.act   = act;
    rq.frame = frame;
    request_q.push_back(rq);
  endtask

  // Wait until every queued beat went in and every result came back
  task automatic wait_idle();
    @(negedge clk_i);
    while (request_q.size() != 0 || in_valid_i || expected_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // APB write: setup then access phase; shadow follows at the access edge
  task automatic write_reg(bpfa_pkg::reg_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == bpfa_pkg::REG_BASE_FRAME) begin
      base_reg = value[23:0];
    end else begin
      count_reg    = value[12:0];
      avail_frames = managed_frames();
    end
  endtask

  task automatic set_config(logic [23:0] base, logic [12:0] count);
    write_reg(bpfa_pkg::REG_BASE_FRAME, 32'(base));
    write_reg(bpfa_pkg::REG_FRAME_COUNT, 32'(count));
  endtask

  // Mostly well-formed traffic around the managed window, some noise
  task automatic queue_random_requests(int unsigned cnt);
    int unsigned n;
    int unsigned span;
    int unsigned pick;
    int unsigned rel;
    int unsigned k;
    logic [23:0] frame;
    n    = managed_frames();
    span = (n < 48) ? n : 48;
    for (k = 0; k < cnt; k++) begin
      pick  = $urandom_range(99);
      rel   = 0;
      if (n != 0) rel = ($urandom_range(3) == 0) ? $urandom_range(n - 1) : $urandom_range(span - 1);
      frame = (n != 0) ? base_reg + 24'(rel) : 24'($urandom());
      if (pick < 38) begin
        queue_request(bpfa_pkg::ACT_ALLOC, 24'($urandom()));
      end else if (pick < 52) begin
        queue_request(bpfa_pkg::ACT_ALLOC_KERN, 24'($urandom()));
      end else if (pick < 80) begin
        queue_request(bpfa_pkg::ACT_FREE, frame);
      end else if (pick < 90) begin
        queue_request(bpfa_pkg::ACT_QUERY, frame);
      end else begin
        // noise: edges of the window and arbitrary frames
        case ($urandom_range(3))
          0:       frame = base_reg - 24'd1;
          1:       frame = base_reg + 24'(n);
          default: frame = 24'($urandom());
        endcase
        queue_request(bpfa_pkg::action_e'($urandom_range(3)), frame);
      end
    end
  endtask

  // Stimulus sequence
  initial begin
    int unsigned p;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset config: alloc, kernel alloc, query classes, frees
    queue_request(bpfa_pkg::ACT_ALLOC, 24'h000000);
    queue_request(bpfa_pkg::ACT_ALLOC_KERN, 24'hFFFFFF);
    queue_request(bpfa_pkg::ACT_QUERY, 24'd1);
    queue_request(bpfa_pkg::ACT_QUERY, 24'd0);
    queue_request(bpfa_pkg::ACT_QUERY, 24'd4096);
    queue_request(bpfa_pkg::ACT_QUERY, 24'hFFFFFF);
    queue_request(bpfa_pkg::ACT_FREE, 24'hFFFFFF);
    queue_request(bpfa_pkg::ACT_FREE, 24'd1);
    queue_request(bpfa_pkg::ACT_FREE, 24'd5);
    queue_request(bpfa_pkg::ACT_ALLOC, 24'h5A5A5A);
    wait_idle();

    // top of the frame space: grants wrap, seven of the eight frames fill
    set_config(24'hFFFFFC, 13'd8);
    queue_request(bpfa_pkg::ACT_ALLOC_KERN, 24'd0);
    queue_request(bpfa_pkg::ACT_ALLOC_KERN, 24'd0);
    queue_request(bpfa_pkg::ACT_ALLOC, 24'd0);
    queue_request(bpfa_pkg::ACT_ALLOC, 24'd0);
    queue_request(bpfa_pkg::ACT_ALLOC_KERN, 24'd0);
    queue_request(bpfa_pkg::ACT_ALLOC, 24'd0);
    queue_request(bpfa_pkg::ACT_ALLOC, 24'd0);
    queue_request(bpfa_pkg::ACT_QUERY, 24'hFFFFFB);
    queue_request(bpfa_pkg::ACT_QUERY, 24'hFFFFFD);
    queue_request(bpfa_pkg::ACT_FREE, 24'hFFFFFD);
    queue_request(bpfa_pkg::ACT_ALLOC, 24'd0);
    queue_request(bpfa_pkg::ACT_FREE, 24'd4);
    wait_idle();

    // empty window
    set_config(24'd0, 13'd0);
    queue_request(bpfa_pkg::ACT_ALLOC, 24'd0);
    queue_request(bpfa_pkg::ACT_FREE, 24'd0);
    queue_request(bpfa_pkg::ACT_QUERY, 24'd0);
    wait_idle();

    // random phases over a spread of windows
    for (p = 0; p < 7; p++) begin
      case (p)
        0:       set_config(24'($urandom()), 13'd16);
        1:       set_config(24'hFFFFFF, 13'd1);
        2:       set_config(24'd0, 13'h1FFF);
        3:       set_config(24'($urandom()), 13'd37);
        4:       set_config(24'hFFFF00, 13'd300);
        5:       set_config(24'($urandom()), 13'($urandom_range(2, MaxFrames)));
        default: set_config(24'($urandom()), 13'(MaxFrames));
      endcase
      calm = (p == 4);
      queue_random_requests(PhaseBeats);
      wait_idle();
    end
    calm = 1'b0;

    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("bitmap_page_frame_allocator_top_tb: PASS");
    end else begin
      $display("bitmap_page_frame_allocator_top_tb: FAIL");
    end
    $finish;
  end

endmodule
